// ===== hw/rtl/wmd_pkg.sv =====
// Shared constants, register codes and types of the waveform min/max decimator.
`timescale 1ns / 1ps

package wmd_pkg;

    // Default field widths
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COORD_BITS_DEF  = 16;

    // Sample index and Q16.16 factors
    localparam int INDEX_BITS = 24;
    localparam int SCALE_BITS = 32;
    localparam int FRAC_BITS  = 16;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_Y_SCALE  = 3'd0,
        REG_BASELINE = 3'd1,
        REG_OFFSET   = 3'd2,
        REG_X_STEP   = 3'd3,
        REG_DECIMATE = 3'd4
    } t_reg_idx;

    // Register reset values
    localparam logic [SCALE_BITS-1:0] Y_SCALE_RST  = 32'h0001_0000;
    localparam logic [SCALE_BITS-1:0] X_STEP_RST   = 32'h0001_0000;
    localparam logic                  DECIMATE_RST = 1'b1;

    // Flags that travel with a request
    typedef struct packed {
        logic first;
        logic last;
    } t_smp_flags;

    // Output serializer status
    typedef struct packed {
        logic       busy;
        logic [1:0] pos;
        logic [1:0] cnt;
    } t_dec_status;

endpackage

// ===== hw/rtl/wmd_ifs.sv =====
// Valid/ready channel interfaces for samples and polyline points.
`timescale 1ns / 1ps

interface wmd_smp_if #(
    parameter int SAMPLE_BITS = wmd_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first;
    logic                          last;

    modport source (output valid, sample, first, last, input ready);
    modport sink   (input valid, sample, first, last, output ready);
endinterface

interface wmd_pt_if #(
    parameter int COORD_BITS = wmd_pkg::COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic        [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         last_point;

    modport source (output valid, x, y, last_point, input ready);
    modport sink   (input valid, x, y, last_point, output ready);
endinterface

// ===== hw/rtl/waveform_minmax_decimator.sv =====
// Top level of the waveform min/max decimator: registers, mapping pipeline, decimator.
// Path: the first point of a sample is offered once the sample has passed the four mapping
//   stages and then the point register of the decimator.
// Throughput: one sample per cycle while each gives at most one point and it is taken; a
//   sample with more holds the point channel and pipeline until all are taken (max 3).
// Reset: synchronous, active low; clears the pipeline, the trace state (index 0, last
//   point (0,0)) and loads the register reset values.
`timescale 1ns / 1ps

module waveform_minmax_decimator #(
    parameter int SAMPLE_BITS = wmd_pkg::SAMPLE_BITS_DEF,
    parameter int COORD_BITS  = wmd_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    wmd_smp_if.sink                        i_smp,
    wmd_pt_if.source                       o_pt,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wmd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [wmd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [wmd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import wmd_pkg::*;

    logic [SCALE_BITS-1:0]         w_y_scale;
    logic signed [COORD_BITS-1:0]  w_baseline;
    logic signed [SAMPLE_BITS-1:0] w_offset;
    logic [SCALE_BITS-1:0]         w_x_step;
    logic                          w_decimate;

    logic                          w_m_valid;
    logic                          w_d_ready;
    logic [COORD_BITS-1:0]         w_m_x;
    logic signed [COORD_BITS-1:0]  w_m_y;
    t_smp_flags                    w_m_flags;
    t_dec_status                   w_dst;

    wmd_apb_regs #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_y_scale  (w_y_scale),
        .o_baseline (w_baseline),
        .o_offset   (w_offset),
        .o_x_step   (w_x_step),
        .o_decimate (w_decimate)
    );

    wmd_map #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (i_smp),
        .i_y_scale  (w_y_scale),
        .i_baseline (w_baseline),
        .i_offset   (w_offset),
        .i_x_step   (w_x_step),
        .o_valid    (w_m_valid),
        .i_ready    (w_d_ready),
        .o_x        (w_m_x),
        .o_y        (w_m_y),
        .o_flags    (w_m_flags)
    );

    wmd_decim #(
        .COORD_BITS (COORD_BITS)
    ) u_decim (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_m_valid),
        .o_ready    (w_d_ready),
        .i_x        (w_m_x),
        .i_y        (w_m_y),
        .i_flags    (w_m_flags),
        .i_decimate (w_decimate),
        .o_pt       (o_pt),
        .o_status   (w_dst)
    );

    // Serializer position stays inside its bundle
    a_pos_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dst.busy |-> (w_dst.pos < w_dst.cnt))
        else $error("point position beyond bundle size");

    // A sample that opens a trace yields exactly one point
    a_first_one_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_m_valid && w_d_ready && w_m_flags.first)
        |=> (w_dst.busy && w_dst.cnt == 2'd1 && w_dst.pos == 2'd0))
        else $error("first sample did not give a single point");

    // After the closing point of a bundle, delivery restarts at its head
    a_bundle_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pt.valid && o_pt.ready && o_pt.last_point) |=> (!w_dst.busy || w_dst.pos == 2'd0))
        else $error("new bundle does not start at its first point");

    // No point offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pt.valid)
        else $error("point offered after reset");

endmodule

// ===== hw/rtl/wmd_apb_regs.sv =====
// APB configuration registers of the decimator.
`timescale 1ns / 1ps

module wmd_apb_regs #(
    parameter int SAMPLE_BITS = wmd_pkg::SAMPLE_BITS_DEF,
    parameter int COORD_BITS  = wmd_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wmd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [wmd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [wmd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [wmd_pkg::SCALE_BITS-1:0]    o_y_scale,
    output logic signed [COORD_BITS-1:0]      o_baseline,
    output logic signed [SAMPLE_BITS-1:0]     o_offset,
    output logic [wmd_pkg::SCALE_BITS-1:0]    o_x_step,
    output logic                              o_decimate
);
    import wmd_pkg::*;

    logic [SCALE_BITS-1:0]         r_y_scale;
    logic signed [COORD_BITS-1:0]  r_baseline;
    logic signed [SAMPLE_BITS-1:0] r_offset;
    logic [SCALE_BITS-1:0]         r_x_step;
    logic                          r_decimate;

    logic     w_wr;
    t_reg_idx w_idx;

    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign pready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_scale  <= Y_SCALE_RST;
            r_baseline <= '0;
            r_offset   <= '0;
            r_x_step   <= X_STEP_RST;
            r_decimate <= DECIMATE_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_Y_SCALE:  r_y_scale  <= pwdata[SCALE_BITS-1:0];
                REG_BASELINE: r_baseline <= pwdata[COORD_BITS-1:0];
                REG_OFFSET:   r_offset   <= pwdata[SAMPLE_BITS-1:0];
                REG_X_STEP:   r_x_step   <= pwdata[SCALE_BITS-1:0];
                REG_DECIMATE: r_decimate <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Readback, signed fields sign-extended
    always_comb begin
        unique case (w_idx)
            REG_Y_SCALE:  prdata = APB_DATA_W'(r_y_scale);
            REG_BASELINE: prdata = APB_DATA_W'(r_baseline);
            REG_OFFSET:   prdata = APB_DATA_W'(r_offset);
            REG_X_STEP:   prdata = APB_DATA_W'(r_x_step);
            REG_DECIMATE: prdata = APB_DATA_W'(r_decimate);
            default:      prdata = '0;
        endcase
    end

    assign o_y_scale  = r_y_scale;
    assign o_baseline = r_baseline;
    assign o_offset   = r_offset;
    assign o_x_step   = r_x_step;
    assign o_decimate = r_decimate;

endmodule

// ===== hw/rtl/wmd_map.sv =====
// Four-stage pipeline that maps a sample and its index to a screen column and row.
`timescale 1ns / 1ps

module wmd_map #(
    parameter int SAMPLE_BITS = wmd_pkg::SAMPLE_BITS_DEF,
    parameter int COORD_BITS  = wmd_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    wmd_smp_if.sink                        i_smp,
    input  logic [wmd_pkg::SCALE_BITS-1:0] i_y_scale,
    input  logic signed [COORD_BITS-1:0]   i_baseline,
    input  logic signed [SAMPLE_BITS-1:0]  i_offset,
    input  logic [wmd_pkg::SCALE_BITS-1:0] i_x_step,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [COORD_BITS-1:0]          o_x,
    output logic signed [COORD_BITS-1:0]   o_y,
    output wmd_pkg::t_smp_flags            o_flags
);
    import wmd_pkg::*;

    localparam int D_W  = SAMPLE_BITS + 1;          // sample minus offset
    localparam int YP_W = D_W + SCALE_BITS + 1;     // signed row product
    localparam int T_W  = YP_W - FRAC_BITS;         // truncated row offset
    localparam int YD_W = T_W + 1;                  // baseline minus row offset
    localparam int XP_W = INDEX_BITS + SCALE_BITS;  // column product
    localparam int XC_W = XP_W - FRAC_BITS;         // column before saturation

    localparam logic signed [COORD_BITS-1:0] Y_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] Y_LO = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [INDEX_BITS-1:0]        INDEX_MAX = '1;

    // Stage enables
    logic w_en1, w_en2, w_en3, w_en4, w_acc;

    // Index counter
    logic [INDEX_BITS-1:0] r_index;
    logic [INDEX_BITS-1:0] w_idx;

    // Stage 1
    logic                  r1_v;
    logic signed [D_W-1:0] r1_diff;
    logic [INDEX_BITS-1:0] r1_idx;
    t_smp_flags            r1_fl;
    logic signed [D_W-1:0] w_diff;

    // Stage 2
    logic                   r2_v;
    logic signed [YP_W-1:0] r2_yp;
    logic [XP_W-1:0]        r2_xp;
    t_smp_flags             r2_fl;

    // Stage 3
    logic                   r3_v;
    logic signed [T_W-1:0]  r3_t;
    logic [COORD_BITS-1:0]  r3_x;
    t_smp_flags             r3_fl;
    logic signed [YP_W-1:0] w_bias;
    logic signed [YP_W-1:0] w_ysum;
    logic [XC_W-1:0]        w_xc;

    // Stage 4
    logic                         r4_v;
    logic signed [COORD_BITS-1:0] r4_y;
    logic [COORD_BITS-1:0]        r4_x;
    t_smp_flags                   r4_fl;
    logic signed [YD_W-1:0]       w_yd;
    logic signed [COORD_BITS-1:0] n4_y;

    // Flow control: a stage moves when it is empty or its successor moves
    assign w_en4       = !r4_v | i_ready;
    assign w_en3       = !r3_v | w_en4;
    assign w_en2       = !r2_v | w_en3;
    assign w_en1       = !r1_v | w_en2;
    assign i_smp.ready = w_en1;
    assign w_acc       = i_smp.valid & w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r_index <= '0;
        end else begin
            if (w_en1) r1_v <= i_smp.valid;
            if (w_en2) r2_v <= r1_v;
            if (w_en3) r3_v <= r2_v;
            if (w_en4) r4_v <= r3_v;
            if (w_acc) r_index <= (w_idx == INDEX_MAX) ? INDEX_MAX : w_idx + 1'b1;
        end
    end

    // Stage 1: index and offset removal
    assign w_idx  = i_smp.first ? '0 : r_index;
    assign w_diff = D_W'(i_smp.sample) - D_W'(i_offset);

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_diff     <= w_diff;
            r1_idx      <= w_idx;
            r1_fl.first <= i_smp.first;
            r1_fl.last  <= i_smp.last;
        end
    end

    // Stage 2: the two multiplications
    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_yp <= r1_diff * $signed({1'b0, i_y_scale});
            r2_xp <= XP_W'(r1_idx) * XP_W'(i_x_step);
            r2_fl <= r1_fl;
        end
    end

    // Stage 3: drop fraction (toward zero for rows), saturate column
    assign w_bias = {{(YP_W-FRAC_BITS){1'b0}}, {FRAC_BITS{r2_yp[YP_W-1]}}};
    assign w_ysum = r2_yp + w_bias;
    assign w_xc   = r2_xp[XP_W-1:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_t  <= w_ysum[YP_W-1:FRAC_BITS];
            r3_x  <= (|w_xc[XC_W-1:COORD_BITS]) ? '1 : w_xc[COORD_BITS-1:0];
            r3_fl <= r2_fl;
        end
    end

    // Stage 4: row from baseline, saturated to the coordinate range
    assign w_yd = YD_W'(i_baseline) - YD_W'(r3_t);

    always_comb begin
        if (w_yd[YD_W-1:COORD_BITS-1] == '0 || w_yd[YD_W-1:COORD_BITS-1] == '1) begin
            n4_y = w_yd[COORD_BITS-1:0];
        end else if (w_yd[YD_W-1]) begin
            n4_y = Y_LO;
        end else begin
            n4_y = Y_HI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_y  <= n4_y;
            r4_x  <= r3_x;
            r4_fl <= r3_fl;
        end
    end

    assign o_valid = r4_v;
    assign o_x     = r4_x;
    assign o_y     = r4_y;
    assign o_flags = r4_fl;

endmodule

// ===== hw/rtl/wmd_decim.sv =====
// Column min/max folding and point serializer, up to three points per sample.
`timescale 1ns / 1ps

module wmd_decim #(
    parameter int COORD_BITS = wmd_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [COORD_BITS-1:0]        i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  wmd_pkg::t_smp_flags          i_flags,
    input  logic                         i_decimate,
    wmd_pt_if.source                     o_pt,
    output wmd_pkg::t_dec_status         o_status
);
    import wmd_pkg::*;

    // Trace state: last point and folded extremes of its column
    logic [COORD_BITS-1:0]        r_col;
    logic signed [COORD_BITS-1:0] r_row;
    logic signed [COORD_BITS-1:0] r_min;
    logic signed [COORD_BITS-1:0] r_max;
    logic                         r_coll;

    // Point bundle being delivered
    logic                         r_busy;
    logic [1:0]                   r_pos;
    logic [1:0]                   r_cnt;
    logic [COORD_BITS-1:0]        r_px [3];
    logic signed [COORD_BITS-1:0] r_py [3];

    logic                         w_lastpt, w_out_hs, w_free, w_acc;
    logic                         w_plain, w_fold, w_new, w_same;
    logic signed [COORD_BITS-1:0] w_fmin, w_fmax, w_emin, w_emax, w_ea, w_eb;
    logic                         w_ecoll, w_ext, w_pt;
    logic [1:0]                   n_cnt;
    logic [COORD_BITS-1:0]        n_px [3];
    logic signed [COORD_BITS-1:0] n_py [3];

    // Handshake
    assign w_lastpt = (r_pos == r_cnt - 2'd1);
    assign w_out_hs = r_busy & o_pt.ready;
    assign w_free   = !r_busy | (o_pt.ready & w_lastpt);
    assign w_acc    = i_valid & w_free;
    assign o_ready  = w_free;

    // Sample classification
    assign w_same  = (i_x == r_col);
    assign w_plain = !i_decimate | i_flags.first;
    assign w_fold  = i_decimate & !i_flags.first & w_same;
    assign w_new   = i_decimate & !i_flags.first & !w_same;

    // Extremes after folding this sample in
    assign w_fmin = (i_y < r_min) ? i_y : r_min;
    assign w_fmax = (!(i_y < r_min) && i_y > r_max) ? i_y : r_max;

    // Extremes pair: before the new column, or on a flush within the column
    assign w_ecoll = w_fold ? 1'b1 : r_coll;
    assign w_emin  = w_fold ? w_fmin : r_min;
    assign w_emax  = w_fold ? w_fmax : r_max;
    assign w_ext   = (w_new | (w_fold & i_flags.last)) & w_ecoll
                   & !((r_row <= w_emin && i_y >= w_emax) || (r_row >= w_emax && i_y <= w_emin));
    assign w_ea    = (r_row < i_y) ? w_emin : w_emax;
    assign w_eb    = (r_row < i_y) ? w_emax : w_emin;

    // The sample's own point
    assign w_pt = w_plain | w_new | (w_fold & i_flags.last & (i_y != r_row));

    // Assemble the bundle
    always_comb begin
        if (w_ext) begin
            n_px[0] = r_col;
            n_py[0] = w_ea;
            n_px[1] = r_col;
            n_py[1] = w_eb;
            n_px[2] = i_x;
            n_py[2] = i_y;
            n_cnt   = w_pt ? 2'd3 : 2'd2;
        end else begin
            n_px[0] = i_x;
            n_py[0] = i_y;
            n_px[1] = i_x;
            n_py[1] = i_y;
            n_px[2] = i_x;
            n_py[2] = i_y;
            n_cnt   = w_pt ? 2'd1 : 2'd0;
        end
    end

    // Trace state and serializer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_min  <= '0;
            r_max  <= '0;
            r_coll <= 1'b0;
            r_busy <= 1'b0;
            r_pos  <= '0;
            r_cnt  <= '0;
        end else if (w_acc) begin
            if (w_fold && !i_flags.last) begin
                r_min  <= w_fmin;
                r_max  <= w_fmax;
                r_coll <= 1'b1;
            end else begin
                r_col  <= i_x;
                r_row  <= i_y;
                r_min  <= i_y;
                r_max  <= i_y;
                r_coll <= 1'b0;
            end
            r_busy <= (n_cnt != 2'd0);
            r_pos  <= '0;
            r_cnt  <= n_cnt;
        end else if (w_out_hs) begin
            if (w_lastpt) begin
                r_busy <= 1'b0;
            end else begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    // Bundle payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_px <= n_px;
            r_py <= n_py;
        end
    end

    assign o_pt.valid      = r_busy;
    assign o_pt.x          = r_px[r_pos];
    assign o_pt.y          = r_py[r_pos];
    assign o_pt.last_point = w_lastpt;

    assign o_status.busy = r_busy;
    assign o_status.pos  = r_pos;
    assign o_status.cnt  = r_cnt;

endmodule

// ===== tb/tb_waveform_minmax_decimator.sv =====
// Self-checking testbench of the decimator: directed and random traces against a predictor.
`timescale 1ns / 1ps

module tb_waveform_minmax_decimator;
    import wmd_pkg::*;

    localparam int SMP_W       = 24;
    localparam int CRD_W       = 16;
    localparam int IDLE_PAD    = 24;      // pipeline latency plus a 3-point burst, with margin
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 22;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic                    first;
        logic                    last;
    } t_sample_req;

    typedef struct packed {
        logic        [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic                    last_point;
    } t_poly_point;

    logic i_clk;
    logic i_rst_n;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    wire  [APB_DATA_W-1:0] prdata;
    wire                   pready;

    wmd_smp_if #(.SAMPLE_BITS(SMP_W)) smp ();
    wmd_pt_if  #(.COORD_BITS(CRD_W))  pt ();

    waveform_minmax_decimator #(
        .SAMPLE_BITS(SMP_W),
        .COORD_BITS (CRD_W)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_smp  (smp),
        .o_pt   (pt),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // Register shadow
    logic        [31:0]      cfg_y_scale;
    logic signed [CRD_W-1:0] cfg_baseline;
    logic signed [SMP_W-1:0] cfg_offset;
    logic        [31:0]      cfg_x_step;
    logic                    cfg_decimate;

    // Trace state of the predictor
    logic        [23:0]      trc_index;
    logic        [CRD_W-1:0] trc_col;
    logic signed [CRD_W-1:0] trc_row;
    logic signed [CRD_W-1:0] trc_min;
    logic signed [CRD_W-1:0] trc_max;
    logic                    trc_folded;

    t_poly_point step_pts [4];
    int          step_n;

    t_sample_req sample_q [$];
    t_poly_point poly_points [$];
    t_sample_req tx_req;
    t_poly_point rx_exp;
    int          smp_inflight = 0;
    int          err_cnt      = 0;
    int          tx_idle_pct  = 28;
    int          rx_idle_pct  = 28;
    logic        rx_hold_req  = 1'b0;
    logic        rx_hold_taken = 1'b0;
    int          rx_hold_left = 0;
    int          cyc_cnt      = 0;

    // Clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Screen row of a sample: baseline minus scaled amplitude, truncated toward zero, saturated
    function automatic logic signed [CRD_W-1:0] row_for(logic signed [SMP_W-1:0] s);
        longint          d;
        longint          t;
        longint          y;
        longint unsigned mag;
        begin
            d   = longint'(s) - longint'(cfg_offset);
            mag = (d < 0) ? longint'(-d) : d;
            t   = longint'((mag * {32'd0, cfg_y_scale}) >> 16);
            y   = longint'(cfg_baseline) - ((d < 0) ? -t : t);
            if (y > 32767)
                y = 32767;
            if (y < -32768)
                y = -32768;
            return y[CRD_W-1:0];
        end
    endfunction

    // Column of a sample index, saturated
    function automatic logic [CRD_W-1:0] col_for(logic [23:0] idx);
        longint unsigned p;
        begin
            p = ({40'd0, idx} * {32'd0, cfg_x_step}) >> 16;
            return (p > 65535) ? 16'hFFFF : p[CRD_W-1:0];
        end
    endfunction

    task automatic emit(input logic [CRD_W-1:0] x, input logic signed [CRD_W-1:0] y);
        begin
            step_pts[step_n] = '{x: x, y: y, last_point: 1'b0};
            step_n++;
        end
    endtask

    task automatic open_col(input logic [CRD_W-1:0] x, input logic signed [CRD_W-1:0] y);
        begin
            trc_col    = x;
            trc_row    = y;
            trc_min    = y;
            trc_max    = y;
            trc_folded = 1'b0;
        end
    endtask

    // Pending min/max, skipped when the segment to the new row already spans them
    task automatic flush_extremes(input logic signed [CRD_W-1:0] y);
        begin
            if (trc_folded &&
                !(trc_row <= trc_min && y >= trc_max) &&
                !(trc_row >= trc_max && y <= trc_min)) begin
                if (trc_row < y) begin
                    emit(trc_col, trc_min);
                    emit(trc_col, trc_max);
                end else begin
                    emit(trc_col, trc_max);
                    emit(trc_col, trc_min);
                end
            end
        end
    endtask

    // Predict the points of one accepted sample request
    task automatic trace_sample(input logic signed [SMP_W-1:0] s, input logic fst,
                                input logic lst);
        logic signed [CRD_W-1:0] y;
        logic        [23:0]      idx;
        logic        [CRD_W-1:0] x;
        begin
            step_n    = 0;
            y         = row_for(s);
            idx       = fst ? 24'd0 : trc_index;
            x         = col_for(idx);
            trc_index = (idx != 24'hFF_FFFF) ? idx + 24'd1 : idx;
            if (!cfg_decimate || fst) begin
                emit(x, y);
                open_col(x, y);
            end else if (x == trc_col) begin
                if (y < trc_min)
                    trc_min = y;
                else if (y > trc_max)
                    trc_max = y;
                trc_folded = 1'b1;
            end else begin
                flush_extremes(y);
                emit(x, y);
                open_col(x, y);
            end
            if (cfg_decimate && lst) begin
                flush_extremes(y);
                if (x != trc_col || y != trc_row)
                    emit(x, y);
                open_col(x, y);
            end
            for (int i = 0; i < step_n; i++) begin
                step_pts[i].last_point = (i == step_n - 1);
                poly_points.insert(poly_points.size(), step_pts[i]);
            end
        end
    endtask

    // APB write: setup, access, then release; shadow follows
    task automatic reg_write(input t_reg_idx idx, input logic [31:0] val);
        begin
            @(posedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= val;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            case (idx)
                REG_Y_SCALE:  cfg_y_scale  = val;
                REG_BASELINE: cfg_baseline = val[CRD_W-1:0];
                REG_OFFSET:   cfg_offset   = val[SMP_W-1:0];
                REG_X_STEP:   cfg_x_step   = val;
                REG_DECIMATE: cfg_decimate = val[0];
                default: ;
            endcase
        end
    endtask

    task automatic set_config(input logic [31:0] ys, input logic signed [CRD_W-1:0] bl,
                              input logic signed [SMP_W-1:0] off, input logic [31:0] xs,
                              input logic dec);
        begin
            reg_write(REG_Y_SCALE, ys);
            reg_write(REG_BASELINE, {{16{bl[CRD_W-1]}}, bl});
            reg_write(REG_OFFSET, {{8{off[SMP_W-1]}}, off});
            reg_write(REG_X_STEP, xs);
            reg_write(REG_DECIMATE, {31'd0, dec});
        end
    endtask

    task automatic queue_sample(input int s, input logic fst, input logic lst);
        begin
            sample_q.insert(sample_q.size(), '{sample: s[SMP_W-1:0], first: fst, last: lst});
            smp_inflight++;
        end
    endtask

    // Wait until every request is taken and every point seen, then let the pipeline empty
    task automatic wait_idle();
        begin
            do
                @(posedge i_clk);
            while (smp_inflight != 0 || poly_points.size() != 0);
            repeat (IDLE_PAD) @(posedge i_clk);
        end
    endtask

    // Sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp.valid <= 1'b0;
        end else begin
            if (smp.valid && smp.ready) begin
                trace_sample(smp.sample, smp.first, smp.last);
                smp_inflight--;
            end
            if (!smp.valid || smp.ready) begin
                if (sample_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    tx_req     = sample_q.pop_front();
                    smp.valid  <= 1'b1;
                    smp.sample <= tx_req.sample;
                    smp.first  <= tx_req.first;
                    smp.last   <= tx_req.last;
                end else begin
                    smp.valid <= 1'b0;
                end
            end
        end
    end

    // Point monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pt.ready <= 1'b0;
        end else begin
            if (pt.valid && pt.ready) begin
                if (poly_points.size() == 0) begin
                    $error("unexpected point x=%0d y=%0d last_point=%0b",
                           pt.x, pt.y, pt.last_point);
                    err_cnt++;
                end else begin
                    rx_exp = poly_points.pop_front();
                    if (pt.x !== rx_exp.x) begin
                        $error("x mismatch: expected %0d, actual %0d", rx_exp.x, pt.x);
                        err_cnt++;
                    end
                    if (pt.y !== rx_exp.y) begin
                        $error("y mismatch: expected %0d, actual %0d", rx_exp.y, pt.y);
                        err_cnt++;
                    end
                    if (pt.last_point !== rx_exp.last_point) begin
                        $error("last_point mismatch: expected %0b, actual %0b",
                               rx_exp.last_point, pt.last_point);
                        err_cnt++;
                    end
                end
            end
            if (rx_hold_req && !rx_hold_taken) begin
                rx_hold_left  = HOLD_CYCLES;
                rx_hold_taken = 1'b1;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                pt.ready <= 1'b0;
            end else begin
                pt.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int          v;
        int          amp;
        int          len;
        int          n_items;
        int          pick;
        logic [31:0] ys;
        logic [31:0] xs;
        logic [15:0] bl;
        logic [23:0] off;
        logic        dec;

        smp.valid  = 1'b0;
        smp.sample = '0;
        smp.first  = 1'b0;
        smp.last   = 1'b0;
        pt.ready   = 1'b0;
        i_rst_n    = 1'b0;

        // Shadow at reset values
        cfg_y_scale  = Y_SCALE_RST;
        cfg_baseline = '0;
        cfg_offset   = '0;
        cfg_x_step   = X_STEP_RST;
        cfg_decimate = DECIMATE_RST;
        trc_index    = '0;
        open_col('0, '0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: sample ahead of any first, extremes, restart after last
        queue_sample(5, 1'b0, 1'b0);
        queue_sample(-3, 1'b0, 1'b0);
        queue_sample(8388607, 1'b1, 1'b0);
        queue_sample(-8388608, 1'b0, 1'b0);
        queue_sample(0, 1'b0, 1'b1);
        queue_sample(100, 1'b0, 1'b0);
        wait_idle();

        // Four samples per column: fold, emit extremes on column change, flush on last
        set_config(32'h0000_4000, 0, 0, 32'h0000_4000, 1'b1);
        queue_sample(0, 1'b1, 1'b0);
        queue_sample(400, 1'b0, 1'b0);
        queue_sample(-400, 1'b0, 1'b0);
        queue_sample(40, 1'b0, 1'b0);
        queue_sample(200, 1'b0, 1'b0);
        queue_sample(-40, 1'b0, 1'b0);
        queue_sample(-2000, 1'b0, 1'b1);
        wait_idle();

        // Zero span
        set_config(32'd0, 240, 0, 32'h0001_0000, 1'b1);
        queue_sample(1234, 1'b1, 1'b0);
        queue_sample(-8388608, 1'b0, 1'b0);
        queue_sample(8388607, 1'b0, 1'b1);
        wait_idle();

        // Plain mode with extreme settings, row and column saturation
        set_config(32'hFFFF_FFFF, 32767, -8388608, 32'hFFFF_FFFF, 1'b0);
        queue_sample(0, 1'b1, 1'b0);
        queue_sample(8388607, 1'b0, 1'b0);
        queue_sample(-8388608, 1'b0, 1'b1);
        queue_sample(77, 1'b0, 1'b0);
        wait_idle();

        // Back to decimation within the same trace
        set_config(32'h0000_0100, 0, 0, 32'h0000_8000, 1'b1);
        queue_sample(500, 1'b0, 1'b0);
        queue_sample(-500, 1'b0, 1'b0);
        queue_sample(9, 1'b0, 1'b1);
        wait_idle();

        // Random phases, each under its own settings
        for (int phase = 0; phase < 8; phase++) begin
            tx_idle_pct = 28;
            rx_idle_pct = 28;
            if (phase == 0) begin
                set_config(32'hFFFF_FFFF, 32767, -8388608, 32'hFFFF_FFFF, 1'b1);
            end else if (phase == 1) begin
                set_config(32'd0, -32768, 8388607, 32'd0, 1'b1);
            end else begin
                pick = $urandom_range(3);
                case (pick)
                    0:       ys = 32'd0;
                    1:       ys = $urandom;
                    2:       ys = $urandom_range(1, 512);
                    default: ys = 32'h0001_0000;
                endcase
                pick = $urandom_range(4);
                case (pick)
                    0:       xs = $urandom;
                    1:       xs = 32'hFFFF_FFFF;
                    default: xs = 32'h0001_0000 >> $urandom_range(0, 4);
                endcase
                bl  = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 480));
                off = ($urandom_range(1) == 0) ? 24'($urandom) : 24'd0;
                dec = (phase == 3) ? 1'b0 : ($urandom_range(3) != 0);
                set_config(ys, bl, off, xs, dec);
            end
            // Pressure phase: sender never idles while the receiver holds off
            if (phase == 2)
                tx_idle_pct = 0;
            // Stretch with no idling on either side
            if (phase == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            n_items = 0;
            while (n_items < PHASE_ITEMS) begin
                if ($urandom_range(99) < 80) begin
                    // Well-formed trace with random-walk content
                    len  = $urandom_range(2, 12);
                    pick = $urandom_range(2);
                    amp  = (pick == 0) ? 16 : ((pick == 1) ? 4096 : 8388607);
                    v    = int'($urandom_range(0, 16777215)) - 8388608;
                    for (int j = 0; j < len; j++) begin
                        v = v + int'($urandom_range(0, 2 * amp)) - amp;
                        if (v > 8388607)
                            v = 8388607;
                        if (v < -8388608)
                            v = -8388608;
                        queue_sample(v, j == 0, j == len - 1);
                    end
                    n_items += len;
                end else begin
                    // Noise: any value, any flags
                    queue_sample(int'($urandom), $urandom_range(3) == 0,
                                 $urandom_range(3) == 0);
                    n_items++;
                end
            end
            if (phase == 2)
                rx_hold_req <= 1'b1;
            wait_idle();
        end

        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/wmd_pkg.sv
hw/rtl/wmd_ifs.sv
hw/rtl/wmd_apb_regs.sv
hw/rtl/wmd_map.sv
hw/rtl/wmd_decim.sv
hw/rtl/waveform_minmax_decimator.sv
tb/tb_waveform_minmax_decimator.sv
